### rtl/max_heap_priority_queue_macros.svh
// Assertion macros for the max heap priority queue checker.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Checked only outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mhpq_pkg.sv
// Package for the max heap priority queue: sizes, codes and payload types.
package mhpq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int ADDR_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int IDX_W = ADDR_W + 2;
  localparam int ID_W = 16;
  localparam int PRI_W = 8;
  localparam int COUNT_W = 11;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_EXTRACT = 3'd1,
    CMD_CANCEL  = 3'd2,
    CMD_UPDATE  = 3'd3,
    CMD_PEEK    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  order_id;
    logic [PRI_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    out_id;
    logic [PRI_W-1:0]   out_priority;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CK,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_EX0,
    S_EX1,
    S_PEEK,
    S_SCAN,
    S_CAN_RD,
    S_DONE
  } state_t;

endpackage

### rtl/mhpq_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
module mhpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/max_heap_priority_queue.sv
// Max heap priority queue: one command per request, one response per request.
//
// Requests enter on req_valid/req_ready and carry a command, an id and a
// priority; responses leave on rsp_valid/rsp_ready with status, the entry
// extracted or peeked, and the entry count after the command.
// One request is worked on at a time; req_ready is high only between requests.
// The heap lives in one RAM with a registered read; every step is a RAM read
// followed by a compare and a write back, sifting through a hole kept in a
// register.
// Insert sifts up from the new slot; extract reads the root and the last entry
// and sifts down from the root; peek reads the root; cancel and update scan for
// the id, then sift up or down from the slot where it is found.
// The linear id scan, one RAM read per cycle, sets the worst case.
// The response sits in an output register; while the receiver stalls it
// holds, and a finished request waits in the done state until it drains.
// Reset empties the heap and drops any response; the RAM needs no clearing.
module max_heap_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mhpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mhpq_pkg::rsp_t rsp
);
  import mhpq_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [ADDR_W-1:0] pos, pos_next;
  entry_t cur, cur_next;
  entry_t lv, lv_next;
  logic have_r, have_r_next;
  logic moved, moved_next;
  logic sink_after, sink_after_next;
  logic [CNT_W-1:0] sidx, sidx_next;
  logic pv, pv_next;
  logic [ADDR_W-1:0] pidx, pidx_next;
  logic [2:0] op_cmd, op_cmd_next;
  logic [ID_W-1:0] op_id, op_id_next;
  logic [PRI_W-1:0] op_pri, op_pri_next;
  logic [1:0] res_status, res_status_next;
  logic [ID_W-1:0] res_id, res_id_next;
  logic [PRI_W-1:0] res_pri, res_pri_next;
  logic rsp_valid_next;
  rsp_t rsp_next;

  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, rdata;

  logic [IDX_W-1:0] lidx, ridx, cnt_x;
  logic [ADDR_W-1:0] parent;
  logic [CNT_W-1:0] last;
  logic best_l, best_r;
  logic [PRI_W-1:0] best_pri;

  mhpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign lidx = {1'b0, pos, 1'b1};
  assign ridx = lidx + IDX_W'(1);
  assign cnt_x = IDX_W'(cnt);
  assign parent = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign last = cnt - CNT_W'(1);
  assign best_l = lv.pri > cur.pri;
  assign best_pri = best_l ? lv.pri : cur.pri;
  assign best_r = have_r && (rdata.pri > best_pri);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    cur <= cur_next;
    lv <= lv_next;
    have_r <= have_r_next;
    moved <= moved_next;
    sink_after <= sink_after_next;
    sidx <= sidx_next;
    pv <= pv_next;
    pidx <= pidx_next;
    op_cmd <= op_cmd_next;
    op_id <= op_id_next;
    op_pri <= op_pri_next;
    res_status <= res_status_next;
    res_id <= res_id_next;
    res_pri <= res_pri_next;
    rsp <= rsp_next;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    pos_next = pos;
    cur_next = cur;
    lv_next = lv;
    have_r_next = have_r;
    moved_next = moved;
    sink_after_next = sink_after;
    sidx_next = sidx;
    pv_next = pv;
    pidx_next = pidx;
    op_cmd_next = op_cmd;
    op_id_next = op_id;
    op_pri_next = op_pri;
    res_status_next = res_status;
    res_id_next = res_id;
    res_pri_next = res_pri;
    rsp_next = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    mem_we = 1'b0;
    mem_waddr = pos;
    mem_wdata = cur;
    mem_raddr = '0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_cmd_next = req.command;
          op_id_next = req.order_id;
          op_pri_next = req.priority_req;
          res_status_next = ST_OK;
          res_id_next = '0;
          res_pri_next = '0;
          moved_next = 1'b0;
          sink_after_next = 1'b0;
          sidx_next = '0;
          pv_next = 1'b0;
          state_next = S_DONE;
          case (req.command)
            CMD_INSERT: begin
              if (cnt >= CNT_W'(HEAP_DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                pos_next = cnt[ADDR_W-1:0];
                cur_next = '{id: req.order_id, pri: req.priority_req};
                cnt_next = cnt + CNT_W'(1);
                state_next = S_UP;
              end
            end
            CMD_EXTRACT: begin
              if (cnt == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                mem_raddr = '0;
                state_next = S_EX0;
              end
            end
            CMD_PEEK: begin
              if (cnt == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                mem_raddr = '0;
                state_next = S_PEEK;
              end
            end
            CMD_CANCEL, CMD_UPDATE: begin
              state_next = S_SCAN;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_UP: begin
        if (pos == '0) begin
          if (sink_after && !moved) begin
            state_next = S_DN;
          end else begin
            mem_we = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          mem_raddr = parent;
          state_next = S_UP_CK;
        end
      end

      S_UP_CK: begin
        if (cur.pri > rdata.pri) begin
          mem_we = 1'b1;
          mem_wdata = rdata;
          pos_next = parent;
          moved_next = 1'b1;
          state_next = S_UP;
        end else if (sink_after && !moved) begin
          state_next = S_DN;
        end else begin
          mem_we = 1'b1;
          state_next = S_DONE;
        end
      end

      S_DN: begin
        if (lidx >= cnt_x) begin
          mem_we = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_raddr = lidx[ADDR_W-1:0];
          state_next = S_DN_L;
        end
      end

      S_DN_L: begin
        lv_next = rdata;
        if (ridx < cnt_x) begin
          mem_raddr = ridx[ADDR_W-1:0];
          have_r_next = 1'b1;
        end else begin
          have_r_next = 1'b0;
        end
        state_next = S_DN_R;
      end

      S_DN_R: begin
        if (best_r) begin
          mem_we = 1'b1;
          mem_wdata = rdata;
          pos_next = ridx[ADDR_W-1:0];
          state_next = S_DN;
        end else if (best_l) begin
          mem_we = 1'b1;
          mem_wdata = lv;
          pos_next = lidx[ADDR_W-1:0];
          state_next = S_DN;
        end else begin
          mem_we = 1'b1;
          state_next = S_DONE;
        end
      end

      S_EX0: begin
        res_id_next = rdata.id;
        res_pri_next = rdata.pri;
        mem_raddr = last[ADDR_W-1:0];
        state_next = S_EX1;
      end

      S_EX1: begin
        cur_next = rdata;
        cnt_next = last;
        pos_next = '0;
        state_next = S_DN;
      end

      S_PEEK: begin
        res_id_next = rdata.id;
        res_pri_next = rdata.pri;
        state_next = S_DONE;
      end

      S_SCAN: begin
        if (pv && (rdata.id == op_id)) begin
          pos_next = pidx;
          moved_next = 1'b0;
          if (op_cmd == CMD_CANCEL) begin
            cnt_next = last;
            sink_after_next = 1'b1;
            if (CNT_W'(pidx) == last) begin
              state_next = S_DONE;
            end else begin
              mem_raddr = last[ADDR_W-1:0];
              state_next = S_CAN_RD;
            end
          end else begin
            cur_next = '{id: rdata.id, pri: op_pri};
            sink_after_next = 1'b0;
            state_next = (op_pri > rdata.pri) ? S_UP : S_DN;
          end
        end else if ((cnt == '0) || (pv && (CNT_W'(pidx) == last))) begin
          res_status_next = ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          mem_raddr = sidx[ADDR_W-1:0];
          pidx_next = sidx[ADDR_W-1:0];
          sidx_next = sidx + CNT_W'(1);
          pv_next = 1'b1;
        end
      end

      S_CAN_RD: begin
        cur_next = rdata;
        state_next = S_UP;
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next = '{status: res_status, out_id: res_id, out_priority: res_pri,
                       count: COUNT_W'(cnt)};
          rsp_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/mhpq_chk.sv
// Port checker for the max heap priority queue, bound to the top level.
`include "max_heap_priority_queue_macros.svh"

module mhpq_chk (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input mhpq_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input mhpq_pkg::rsp_t rsp
);
  import mhpq_pkg::*;

  `MHPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response changed while stalled")
  `MHPQ_ASSERT(a_one_req, req_valid && req_ready |=> !req_ready, "second request taken while busy")
  `MHPQ_ASSERT(a_full_cnt, rsp_valid && rsp.status == ST_FULL |-> rsp.count == HEAP_DEPTH, "full status with heap not full")
  `MHPQ_ASSERT(a_empty, rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == 0 && rsp.out_id == 0 && rsp.out_priority == 0, "empty status with data")
  `MHPQ_ASSERT_ALWAYS(a_rst, $past(rst) |-> !rsp_valid, "response valid after reset")

endmodule

bind max_heap_priority_queue mhpq_chk u_chk (.*);
